// ===== sv/dms_pkg.sv =====
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types and constants for the directional movement strength block.
// ----------------------------------------------------------------------------
`default_nettype none

package dms_pkg;

    localparam int PRICE_W = 32;
    localparam int WIN_W   = 6;
    localparam int QUO_W   = 17;
    localparam int CNT_W   = 5;

    localparam logic [WIN_W-1:0] WIN_RESET = 6'd14;

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_UPDATE = 3'b010,
        F_EMIT   = 3'b100
    } front_state_t;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_DONE = 3'b100
    } div_state_t;

endpackage

`default_nettype wire

// ===== sv/dms_front.sv =====
// ----------------------------------------------------------------------------
// dms_front
// Bar intake: directional moves, delay lines, running sums, ratio operands.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_front #(
    parameter int MAX_WINDOW = 32,
    parameter int SUM_W      = 37,
    parameter int TOT_W      = 38
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wr_en,
    input  wire  [dms_pkg::WIN_W-1:0]        cfg_wr_data,
    input  wire                              bar_valid,
    output logic                             bar_ready,
    input  wire  [dms_pkg::PRICE_W-1:0]      high_price,
    input  wire  [dms_pkg::PRICE_W-1:0]      low_price,
    input  wire                              series_start,
    output logic                             job_valid,
    input  wire                              job_ready,
    output logic [SUM_W-1:0]                 job_diff,
    output logic [TOT_W-1:0]                 job_total,
    output logic                             job_live
);
    import dms_pkg::*;

    localparam int PW  = $clog2(MAX_WINDOW);
    localparam int BW  = $clog2(MAX_WINDOW + 3);
    localparam int CW  = (BW > WIN_W) ? BW : WIN_W;
    localparam logic [BW-1:0] BARS_MAX = BW'(MAX_WINDOW + 2);
    localparam logic [CW-1:0] WIN_MAX  = CW'(MAX_WINDOW);

    front_state_t               state_reg, state_next;
    logic [WIN_W-1:0]           window_reg;
    logic [PRICE_W-1:0]         prev_high_reg, prev_high_next;
    logic [PRICE_W-1:0]         prev_low_reg, prev_low_next;
    logic [PRICE_W-1:0]         hi_reg, lo_reg;
    logic [SUM_W-1:0]           plus_sum_reg, plus_sum_next;
    logic [SUM_W-1:0]           minus_sum_reg, minus_sum_next;
    logic [BW-1:0]              bars_reg, bars_next;
    logic [PW-1:0]              ptr_reg, ptr_next;
    logic [PRICE_W-1:0]         rd_plus_reg, rd_minus_reg;

    logic [PRICE_W-1:0]         plus_mem  [MAX_WINDOW];
    logic [PRICE_W-1:0]         minus_mem [MAX_WINDOW];

    logic [CW-1:0]              win_eff;
    logic                       accept;
    logic [PW-1:0]              ptr_start, ptr_wrap, ptr_inc;
    logic signed [PRICE_W:0]    up_move, down_move;
    logic [PRICE_W-1:0]         plus_move, minus_move;
    logic                       have_diff, drop_old;
    logic [SUM_W-1:0]           plus_old, minus_old;

    always_comb
    begin
        win_eff = CW'(window_reg);
        if (window_reg == '0)
        begin
            win_eff = CW'(1);
        end
        else if (CW'(window_reg) > WIN_MAX)
        begin
            win_eff = WIN_MAX;
        end
    end

    assign bar_ready = (state_reg == F_IDLE);
    assign accept    = bar_valid && bar_ready;

    assign ptr_start = series_start ? '0 : ptr_reg;
    assign ptr_wrap  = (CW'(ptr_start) >= win_eff) ? '0 : ptr_start;
    assign ptr_inc   = ((CW'(ptr_reg) + CW'(1)) >= win_eff) ? '0 : PW'(ptr_reg + 1'b1);

    assign up_move   = $signed({1'b0, hi_reg}) - $signed({1'b0, prev_high_reg});
    assign down_move = $signed({1'b0, prev_low_reg}) - $signed({1'b0, lo_reg});
    assign plus_move  = (up_move > down_move && up_move > 0) ? up_move[PRICE_W-1:0] : '0;
    assign minus_move = (down_move > up_move && down_move > 0) ? down_move[PRICE_W-1:0] : '0;

    assign have_diff = (bars_reg != '0);
    assign drop_old  = ((CW+1)'(bars_reg) >= ((CW+1)'(win_eff) + (CW+1)'(1)));
    assign plus_old  = drop_old ? SUM_W'(rd_plus_reg) : '0;
    assign minus_old = drop_old ? SUM_W'(rd_minus_reg) : '0;

    always_comb
    begin
        state_next     = state_reg;
        prev_high_next = prev_high_reg;
        prev_low_next  = prev_low_reg;
        plus_sum_next  = plus_sum_reg;
        minus_sum_next = minus_sum_reg;
        bars_next      = bars_reg;
        ptr_next       = ptr_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    ptr_next = ptr_wrap;
                    if (series_start)
                    begin
                        prev_high_next = '0;
                        prev_low_next  = '0;
                        plus_sum_next  = '0;
                        minus_sum_next = '0;
                        bars_next      = '0;
                    end
                    state_next = F_UPDATE;
                end
            end
            F_UPDATE:
            begin
                if (have_diff)
                begin
                    plus_sum_next  = plus_sum_reg - plus_old + SUM_W'(plus_move);
                    minus_sum_next = minus_sum_reg - minus_old + SUM_W'(minus_move);
                    ptr_next       = ptr_inc;
                end
                prev_high_next = hi_reg;
                prev_low_next  = lo_reg;
                if (bars_reg < BARS_MAX)
                begin
                    bars_next = bars_reg + 1'b1;
                end
                state_next = F_EMIT;
            end
            F_EMIT:
            begin
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
        if (cfg_wr_en)
        begin
            prev_high_next = '0;
            prev_low_next  = '0;
            plus_sum_next  = '0;
            minus_sum_next = '0;
            bars_next      = '0;
            ptr_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            window_reg    <= WIN_RESET;
            prev_high_reg <= '0;
            prev_low_reg  <= '0;
            plus_sum_reg  <= '0;
            minus_sum_reg <= '0;
            bars_reg      <= '0;
            ptr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_high_reg <= prev_high_next;
            prev_low_reg  <= prev_low_next;
            plus_sum_reg  <= plus_sum_next;
            minus_sum_reg <= minus_sum_next;
            bars_reg      <= bars_next;
            ptr_reg       <= ptr_next;
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hi_reg       <= high_price;
            lo_reg       <= low_price;
            rd_plus_reg  <= plus_mem[ptr_wrap];
            rd_minus_reg <= minus_mem[ptr_wrap];
        end
        if (state_reg == F_UPDATE && have_diff)
        begin
            plus_mem[ptr_reg]  <= plus_move;
            minus_mem[ptr_reg] <= minus_move;
        end
    end

    assign job_valid = (state_reg == F_EMIT);
    assign job_live  = ((CW+1)'(bars_reg) >= ((CW+1)'(win_eff) + (CW+1)'(2)));
    assign job_diff  = (plus_sum_reg >= minus_sum_reg) ? (plus_sum_reg - minus_sum_reg)
                                                       : (minus_sum_reg - plus_sum_reg);
    assign job_total = TOT_W'(plus_sum_reg) + TOT_W'(minus_sum_reg);

endmodule

`default_nettype wire

// ===== sv/dms_queue.sv =====
// ----------------------------------------------------------------------------
// dms_queue
// Two-entry queue between the bar intake and the ratio divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_queue #(
    parameter int DATA_W = 76
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [DATA_W-1:0]   in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [DATA_W-1:0]   out_data
);
    import dms_pkg::*;

    logic [DATA_W-1:0]  slot_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dms_divider.sv =====
// ----------------------------------------------------------------------------
// dms_divider
// Restoring divider: strength = floor(diff * 2^16 / total), one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_divider #(
    parameter int SUM_W = 37,
    parameter int TOT_W = 38
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         job_valid,
    output logic                        job_ready,
    input  wire  [SUM_W-1:0]            job_diff,
    input  wire  [TOT_W-1:0]            job_total,
    input  wire                         job_live,
    output logic                        res_valid,
    input  wire                         res_ready,
    output logic [dms_pkg::QUO_W-1:0]   trend_strength,
    output logic                        strength_valid
);
    import dms_pkg::*;

    div_state_t         state_reg, state_next;
    logic [TOT_W-1:0]   rem_reg, rem_next;
    logic [TOT_W-1:0]   den_reg, den_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               live_reg, live_next;
    logic [TOT_W:0]     rem_shift;
    logic               fits;

    assign rem_shift = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        live_next  = live_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (job_valid)
                begin
                    live_next = job_live;
                    rem_next  = TOT_W'(job_diff);
                    den_next  = job_total;
                    quo_next  = '0;
                    cnt_next  = '0;
                    if (!job_live || job_total == '0)
                    begin
                        state_next = D_DONE;
                    end
                    else
                    begin
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN:
            begin
                rem_next = fits ? TOT_W'(rem_shift - {1'b0, den_reg}) : TOT_W'(rem_shift);
                quo_next = {quo_reg[QUO_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                if (res_ready)
                begin
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            live_reg  <= 1'b0;
            quo_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            live_reg  <= live_next;
            quo_reg   <= quo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign job_ready      = (state_reg == D_IDLE);
    assign res_valid      = (state_reg == D_DONE);
    assign trend_strength = live_reg ? quo_reg : '0;
    assign strength_valid = live_reg;

endmodule

`default_nettype wire

// ===== sv/directional_movement_strength.sv =====
// ----------------------------------------------------------------------------
// directional_movement_strength
// DX-style trend strength |S+ - S-| / (S+ + S-) in Q16 over a window of bars.
//
// s_* channel: one price bar per beat; tuser set starts a new series.
// m_* channel: one result beat per bar; tuser flags a valid strength
// (window_length + 2 bars seen), otherwise tdata is 0.
// cfg_wr_en/cfg_wr_data: window length (0 acts as 1, clamped to MAX_WINDOW);
// a write also clears the history. Write only while the block is idle.
// Path: the intake updates its sums and offers the result, the queue hands it
// over, and the divider runs 17 restoring steps and holds the result beat. A
// bar with no valid strength, or with a zero total, skips the divide. Intake
// takes a new bar only once its last result is in the queue; the divider takes
// a new bar only once its last result beat has been taken.
// A two-entry queue lets intake run ahead while the divider or the
// receiver stalls; a stalled result holds on m_tdata/m_tuser.
// Reset: window length 14, history cleared, both channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_movement_strength #(
    parameter int MAX_WINDOW = 32
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_wr_en,
    input  wire  [5:0]   cfg_wr_data,   // window_length
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [63:0]  s_tdata,       // [31:0] high_price, [63:32] low_price
    input  wire          s_tuser,       // series_start
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [23:0]  m_tdata,       // [16:0] trend_strength, [23:17] zero
    output logic         m_tuser        // strength_valid
);
    import dms_pkg::*;

    localparam int SUM_W  = PRICE_W + $clog2(MAX_WINDOW);
    localparam int TOT_W  = SUM_W + 1;
    localparam int DATA_W = SUM_W + TOT_W + 1;

    logic                job_valid, job_ready;
    logic [SUM_W-1:0]    job_diff;
    logic [TOT_W-1:0]    job_total;
    logic                job_live;
    logic                dq_valid, dq_ready;
    logic [DATA_W-1:0]   dq_data;
    logic [QUO_W-1:0]    trend_strength;

    dms_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .SUM_W      (SUM_W),
        .TOT_W      (TOT_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .bar_valid    (s_tvalid),
        .bar_ready    (s_tready),
        .high_price   (s_tdata[31:0]),
        .low_price    (s_tdata[63:32]),
        .series_start (s_tuser),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job_diff     (job_diff),
        .job_total    (job_total),
        .job_live     (job_live)
    );

    dms_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (job_valid),
        .in_ready  (job_ready),
        .in_data   ({job_live, job_total, job_diff}),
        .out_valid (dq_valid),
        .out_ready (dq_ready),
        .out_data  (dq_data)
    );

    dms_divider #(
        .SUM_W (SUM_W),
        .TOT_W (TOT_W)
    ) u_divider (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (dq_valid),
        .job_ready      (dq_ready),
        .job_diff       (dq_data[SUM_W-1:0]),
        .job_total      (dq_data[SUM_W +: TOT_W]),
        .job_live       (dq_data[DATA_W-1]),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .trend_strength (trend_strength),
        .strength_valid (m_tuser)
    );

    assign m_tdata = {7'd0, trend_strength};

endmodule

`default_nettype wire

// ===== verif/dms_checker.sv =====
// ----------------------------------------------------------------------------
// dms_checker
// Watches the bar and result streams and the window register port, predicts
// each strength beat from the accepted bars and compares it in order.
// ----------------------------------------------------------------------------

module dms_checker #(
    parameter int MAX_WINDOW = 32
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_wr_en,
    input  wire  [5:0]   cfg_wr_data,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire  [63:0]  s_tdata,
    input  wire          s_tuser,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [23:0]  m_tdata,
    input  wire          m_tuser,
    output int           error_count,
    output int           pending_count,
    output int           result_count,
    output int           valid_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import dms_pkg::*;

    typedef struct packed {
        logic [QUO_W-1:0] strength;
        logic             valid;
    } strength_beat_t;

    logic [WIN_W-1:0]   window_reg;
    logic [PRICE_W-1:0] prev_high;
    logic [PRICE_W-1:0] prev_low;
    logic [PRICE_W-1:0] plus_line  [MAX_WINDOW];
    logic [PRICE_W-1:0] minus_line [MAX_WINDOW];
    logic [63:0]        plus_sum;
    logic [63:0]        minus_sum;
    int unsigned        bars;
    int unsigned        slot;

    strength_beat_t     expected_strengths [$];

    function automatic void clear_history();
        prev_high = '0;
        prev_low  = '0;
        plus_sum  = '0;
        minus_sum = '0;
        bars      = 0;
        slot      = 0;
    endfunction

    function automatic strength_beat_t predict_strength(input logic [PRICE_W-1:0] hi,
                                                        input logic [PRICE_W-1:0] lo,
                                                        input logic start);
        int unsigned        w;
        longint             up;
        longint             down;
        logic [PRICE_W-1:0] plus_mv;
        logic [PRICE_W-1:0] minus_mv;
        logic [63:0]        total;
        logic [63:0]        diff;
        logic [63:0]        ratio;
        strength_beat_t     r;

        if (start)
            clear_history();
        if (window_reg == 0)
            w = 1;
        else if (window_reg > MAX_WINDOW)
            w = MAX_WINDOW;
        else
            w = window_reg;
        if (slot >= w)
            slot = 0;

        if (bars >= 1)
        begin
            up   = $signed({32'd0, hi}) - $signed({32'd0, prev_high});
            down = $signed({32'd0, prev_low}) - $signed({32'd0, lo});
            plus_mv  = (up > down && up > 0) ? up[31:0] : '0;
            minus_mv = (down > up && down > 0) ? down[31:0] : '0;
            if (bars >= w + 1)
            begin
                plus_sum  -= plus_line[slot];
                minus_sum -= minus_line[slot];
            end
            plus_line[slot]  = plus_mv;
            minus_line[slot] = minus_mv;
            plus_sum  += plus_mv;
            minus_sum += minus_mv;
            slot = (slot + 1 >= w) ? 0 : slot + 1;
        end

        prev_high = hi;
        prev_low  = lo;
        if (bars < MAX_WINDOW + 2)
            bars++;

        r.valid    = (bars >= w + 2);
        r.strength = '0;
        if (r.valid)
        begin
            total = plus_sum + minus_sum;
            if (total != 0)
            begin
                diff  = (plus_sum >= minus_sum) ? plus_sum - minus_sum : minus_sum - plus_sum;
                ratio = (diff << 16) / total;
                if (ratio > 64'd65536)
                    ratio = 64'd65536;
                r.strength = ratio[QUO_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        strength_beat_t exp_beat;
        if (!rst_n)
        begin
            window_reg = WIN_RESET;
            clear_history();
            expected_strengths.delete();
            error_count   = 0;
            pending_count = 0;
            result_count  = 0;
            valid_count   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_reg = cfg_wr_data;
                clear_history();
            end

            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (expected_strengths.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: result beat with nothing outstanding: strength %0d valid %0b",
                                 $realtime, m_tdata[QUO_W-1:0], m_tuser);
                end
                else
                begin
                    exp_beat = expected_strengths.pop_front();
                    if (exp_beat.valid)
                        valid_count++;
                    if (m_tdata[QUO_W-1:0] !== exp_beat.strength || m_tuser !== exp_beat.valid
                        || m_tdata[23:QUO_W] !== '0)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: result %0d: expected %0d/%0b, got %0d/%0b pad %0h",
                                     $realtime, result_count, exp_beat.strength, exp_beat.valid,
                                     m_tdata[QUO_W-1:0], m_tuser, m_tdata[23:QUO_W]);
                    end
                end
            end

            if (s_tvalid && s_tready)
                expected_strengths.push_back(predict_strength(s_tdata[31:0], s_tdata[63:32],
                                                              s_tuser));

            pending_count = expected_strengths.size();
        end
    end

endmodule

// ===== verif/directional_movement_strength_tb.sv =====
// ----------------------------------------------------------------------------
// directional_movement_strength_tb
// Drives price bars and window settings into the block with random gaps and
// back-pressure; the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------

module directional_movement_strength_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD  = 10;
    localparam int     MAX_WINDOW  = 32;
    localparam int     HOLD_CYCLES = 400;
    localparam int     CYCLE_LIMIT = 500000;
    localparam longint MID_LOW     = 64'd1048576;
    localparam longint MID_HIGH    = 64'd4293918720;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata     = '0;      // [31:0] high_price, [63:32] low_price
    logic        s_tuser     = 1'b0;    // series_start
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;               // [16:0] trend_strength, [23:17] zero
    logic        m_tuser;               // strength_valid

    logic        steady      = 1'b0;
    logic        rx_hold     = 1'b0;
    logic        hold_req    = 1'b0;
    int          cycle_count = 0;
    int          bars_sent   = 0;
    int          windows_run = 1;
    longint      price_mid   = 64'd2147483648;
    logic [31:0] last_hi     = '0;
    logic [31:0] last_lo     = '0;

    int          chk_errors;
    int          chk_pending;
    int          chk_results;
    int          chk_valid;

    always #(CLK_PERIOD / 2) clk = ~clk;

    directional_movement_strength #(
        .MAX_WINDOW (MAX_WINDOW)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    dms_checker #(
        .MAX_WINDOW (MAX_WINDOW)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (chk_errors),
        .pending_count (chk_pending),
        .result_count  (chk_results),
        .valid_count   (chk_valid)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     chk_pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= rx_hold ? 1'b0 : (steady ? 1'b1 : ($urandom_range(99) >= 22));

    // long receiver stall so the intake queue fills and back-pressures
    initial
    begin
        wait (hold_req);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo, input logic start);
        while (!steady && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        bars_sent++;
        @(negedge clk);
    endtask

    task automatic set_window(input logic [5:0] w);
        s_tvalid <= 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        windows_run++;
    endtask

    task automatic run_phase(input int n_bars, input int hold_at, input logic no_idle);
        int unsigned span;
        int unsigned roll;
        int unsigned rng;
        longint      step;
        logic [31:0] hi;
        logic [31:0] lo;
        logic        start;
        steady <= no_idle;
        span = 32'd1 << $urandom_range(2, 18);
        for (int i = 0; i < n_bars; i++)
        begin
            roll  = $urandom_range(99);
            start = ($urandom_range(99) < 2);
            if (start)
                span = 32'd1 << $urandom_range(2, 18);
            if (roll < 8)
            begin
                hi = $urandom;
                lo = $urandom;
            end
            else if (roll < 12)
            begin
                hi = last_hi;
                lo = last_lo;
            end
            else if (roll < 15)
            begin
                hi = $urandom_range(1) ? '1 : '0;
                lo = $urandom_range(1) ? '1 : '0;
            end
            else
            begin
                step = longint'($urandom_range(2 * span)) - longint'(span);
                price_mid += step;
                if (price_mid < MID_LOW)
                    price_mid = MID_LOW;
                if (price_mid > MID_HIGH)
                    price_mid = MID_HIGH;
                rng = $urandom_range(span);
                hi  = 32'(price_mid + rng);
                lo  = 32'(price_mid - rng);
                if (roll < 18)
                begin
                    hi = lo;
                    lo = 32'(price_mid + rng);
                end
            end
            last_hi = hi;
            last_lo = lo;
            if (i == hold_at)
                hold_req = 1'b1;
            send_bar(hi, lo, start);
        end
        steady <= 1'b0;
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset window of 14
        run_phase(80, -1, 1'b0);

        // window 0 acts as 1
        set_window(6'd0);
        send_bar(32'd100, 32'd90, 1'b1);
        send_bar(32'd110, 32'd95, 1'b0);
        send_bar(32'd120, 32'd80, 1'b0);
        send_bar(32'd125, 32'd75, 1'b0);
        send_bar(32'd120, 32'd80, 1'b0);
        send_bar(32'd130, 32'd78, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'd0, 1'b0);
        send_bar(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_bar(32'd10, 32'hFFFF_FFFF, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_bar(32'd0, 32'd0, 1'b0);
        send_bar(32'd5, 32'd3, 1'b1);
        send_bar(32'd7, 32'd1, 1'b0);
        send_bar(32'd9, 32'd0, 1'b0);

        set_window(6'd3);
        send_bar(32'h0064_0000, 32'h005A_0000, 1'b0);
        send_bar(32'h006E_0000, 32'h005F_0000, 1'b0);
        send_bar(32'h0070_0000, 32'h0050_0000, 1'b0);
        send_bar(32'h0073_0000, 32'h0055_0000, 1'b0);
        send_bar(32'h0071_0000, 32'h0046_0000, 1'b0);
        send_bar(32'h007A_0000, 32'h0048_0000, 1'b0);
        send_bar(32'h0080_8000, 32'h0049_0000, 1'b0);

        set_window(6'd1);
        run_phase(90, -1, 1'b0);
        set_window(6'd2);
        run_phase(90, 10, 1'b0);
        set_window(6'd32);
        run_phase(150, -1, 1'b0);
        set_window(6'd33);
        run_phase(100, -1, 1'b0);
        set_window(6'd63);
        run_phase(90, -1, 1'b0);
        set_window(6'd5);
        run_phase(90, -1, 1'b1);
        repeat (2)
        begin
            set_window(6'($urandom_range(63)));
            run_phase(80, -1, 1'b0);
        end
        set_window(6'd14);
        run_phase(100, -1, 1'b0);

        s_tvalid <= 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("run covered %0d bars over %0d window settings, including 0, 1, 32 and 63",
                 bars_sent, windows_run);
        $display("%0d strength beats checked, %0d of them valid, %0d mismatches",
                 chk_results, chk_valid, chk_errors);
        if (chk_errors == 0 && chk_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
